// File: rtl/ggns_pkg.sv
// shared types and constants for the greedy nearest search block
`default_nettype none
package ggns_pkg;

    typedef enum logic [1:0] {
        CMD_VEC   = 2'd0,
        CMD_NBR   = 2'd1,
        CMD_DEG   = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_ENTRY = 3'd0,
        CFG_LIVE  = 3'd1,
        CFG_LIMIT = 3'd2,
        CFG_DIMS  = 3'd3,
        CFG_NODES = 3'd4
    } t_cfg_idx;

    localparam logic [39:0] DIST_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [10:0] NODE_NONE = 11'h7FF;

    // table and query writes toward the walk engine
    typedef struct packed {
        logic               we_vec;
        logic               we_nbr;
        logic               we_deg;
        logic               we_query;
        logic [9:0]         node;
        logic [5:0]         slot;
        logic [6:0]         elem_index;
        logic signed [15:0] elem_value;
        logic [10:0]        nbr_id;
        logic [6:0]         degree;
        logic               deleted_mark;
    } t_wcmd;

    // settings of one walk, already capped
    typedef struct packed {
        logic [10:0] entry;
        logic [16:0] n_eff;
        logic [10:0] d_eff;
        logic [15:0] limit;
    } t_walk_cfg;

    typedef struct packed {
        logic        done;
        logic [10:0] node;
        logic [39:0] best_dist;
    } t_walk_res;

endpackage
`default_nettype wire

// File: rtl/ggns_dist.sv
// pipelined squared l2 accumulator with saturation
`default_nettype none
module ggns_dist import ggns_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_first,
    input  wire logic               i_last,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    output logic                    o_valid,
    output logic [39:0]             o_dist
);

    logic               r_d_v, r_d_f, r_d_l;
    logic signed [16:0] r_diff;
    logic               r_s_v, r_s_f, r_s_l;
    logic [31:0]        r_sq;
    logic [39:0]        r_acc;
    logic               r_out_v;

    logic [15:0] w_abs;
    logic [40:0] w_sum;
    logic [39:0] w_base;

    assign w_abs  = r_diff[16] ? 16'(-r_diff) : r_diff[15:0];
    assign w_base = r_s_f ? 40'd0 : r_acc;
    assign w_sum  = 41'(w_base) + 41'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v   <= 1'b0;
            r_s_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_d_v   <= i_valid;
            r_s_v   <= r_d_v;
            r_out_v <= r_s_v && r_s_l;
        end
        r_d_f  <= i_first;
        r_d_l  <= i_last;
        r_diff <= 17'(i_a) - 17'(i_b);
        r_s_f  <= r_d_f;
        r_s_l  <= r_d_l;
        r_sq   <= 32'(w_abs) * 32'(w_abs);
        if (r_s_v) begin
            r_acc <= (w_sum > 41'(DIST_MAX)) ? DIST_MAX : w_sum[39:0];
        end
    end

    assign o_valid = r_out_v;
    assign o_dist  = r_acc;

endmodule
`default_nettype wire

// File: rtl/ggns_walk.sv
// table memories and the greedy walk sequencer
`default_nettype none
module ggns_walk import ggns_pkg::*; #(
    parameter int NODES  = 1024,
    parameter int DEGREE = 64,
    parameter int DIMS   = 128
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_wcmd     i_cmd,
    input  wire logic      i_go,
    input  wire t_walk_cfg i_cfg,
    output logic           o_busy,
    output t_walk_res      o_res
);

    localparam int NW   = $clog2(NODES);
    localparam int DGCW = $clog2(DEGREE + 1);
    localparam int DIW  = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int DCW  = $clog2(DIMS + 1);
    localparam int VAW  = $clog2(NODES * DIMS);
    localparam int NAW  = $clog2(NODES * DEGREE);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_ISSUE = 10'b00_0000_0100,
        S_WAIT  = 10'b00_0000_1000,
        S_CHK   = 10'b00_0001_0000,
        S_DEG   = 10'b00_0010_0000,
        S_NB    = 10'b00_0100_0000,
        S_DEL   = 10'b00_1000_0000,
        S_NEXT  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    logic signed [15:0] vmem [NODES*DIMS];
    logic [10:0]        nmem [NODES*DEGREE];
    logic [7:0]         dmem [NODES];
    logic signed [15:0] qmem [DIMS];

    t_state             r_state, n_state;
    logic [NW-1:0]      r_clr, n_clr;
    t_walk_cfg          r_cfg, n_cfg;
    logic [NW-1:0]      r_cur, n_cur;
    logic [VAW-1:0]     r_vbase, n_vbase;
    logic [NAW-1:0]     r_nbase, n_nbase;
    logic [DCW-1:0]     r_ei, n_ei;
    logic [15:0]        r_it, n_it;
    logic [DGCW-1:0]    r_slot, n_slot;
    logic [DGCW-1:0]    r_degn, n_degn;
    logic [NW-1:0]      r_nb, n_nb;
    logic [NW-1:0]      r_bnode, n_bnode;
    logic [39:0]        r_bdist, n_bdist;
    logic               r_imp, n_imp;
    logic               r_entry, n_entry;
    logic               r_zero, n_zero;
    logic               r_done, n_done;
    logic               r_iv, r_if, r_il;
    logic               w_iv, w_if, w_il;
    logic signed [15:0] r_vq, r_qq;
    logic [10:0]        r_nq;
    logic [7:0]         r_dq;

    logic               w_node_ok, w_slot_ok, w_ei_ok;
    logic [VAW-1:0]     w_vra;
    logic [NAW-1:0]     w_nra;
    logic [NW-1:0]      w_dra;
    logic [DGCW-1:0]    w_nslot;
    logic [DCW-1:0]     w_deff;
    logic               w_u_v;
    logic [39:0]        w_u_d;
    logic               w_dv;
    logic [39:0]        w_dd;
    logic               w_nb_ok;

    assign w_node_ok = 32'(i_cmd.node) < NODES;
    assign w_slot_ok = 32'(i_cmd.slot) < DEGREE;
    assign w_ei_ok   = 32'(i_cmd.elem_index) < DIMS;

    assign w_deff  = DCW'(r_cfg.d_eff);
    assign w_nslot = r_slot + 1'b1;
    assign w_vra   = r_vbase + VAW'(r_ei);
    assign w_nra   = r_nbase + NAW'((r_state == S_NEXT) ? w_nslot : r_slot);
    assign w_dra   = (r_state == S_NB) ? NW'(r_nq) : r_cur;
    assign w_nb_ok = !r_nq[10] && (17'(r_nq) < r_cfg.n_eff);

    // memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.we_vec && w_node_ok && w_ei_ok) begin
            vmem[VAW'(i_cmd.node) * VAW'(DIMS) + VAW'(i_cmd.elem_index)] <= i_cmd.elem_value;
        end
        r_vq <= vmem[w_vra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we_query && w_ei_ok) begin
            qmem[DIW'(i_cmd.elem_index)] <= i_cmd.elem_value;
        end
        r_qq <= qmem[DIW'(r_ei)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we_nbr && w_node_ok && w_slot_ok) begin
            nmem[NAW'(i_cmd.node) * NAW'(DEGREE) + NAW'(i_cmd.slot)] <= i_cmd.nbr_id;
        end
        r_nq <= nmem[w_nra];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            dmem[r_clr] <= 8'd0;
        end else if (i_cmd.we_deg && w_node_ok) begin
            dmem[NW'(i_cmd.node)] <= {i_cmd.deleted_mark, i_cmd.degree};
        end
        r_dq <= dmem[w_dra];
    end

    ggns_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_iv),
        .i_first (r_if),
        .i_last  (r_il),
        .i_a     (r_vq),
        .i_b     (r_qq),
        .o_valid (w_u_v),
        .o_dist  (w_u_d)
    );

    assign w_dv = w_u_v || r_zero;
    assign w_dd = r_zero ? 40'd0 : w_u_d;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cfg   = r_cfg;
        n_cur   = r_cur;
        n_vbase = r_vbase;
        n_nbase = r_nbase;
        n_ei    = r_ei;
        n_it    = r_it;
        n_slot  = r_slot;
        n_degn  = r_degn;
        n_nb    = r_nb;
        n_bnode = r_bnode;
        n_bdist = r_bdist;
        n_imp   = r_imp;
        n_entry = r_entry;
        n_zero  = 1'b0;
        n_done  = 1'b0;
        w_iv    = 1'b0;
        w_if    = 1'b0;
        w_il    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == NODES - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_go) begin
                    n_cfg   = i_cfg;
                    n_cur   = NW'(i_cfg.entry);
                    n_vbase = VAW'(i_cfg.entry) * VAW'(DIMS);
                    n_it    = 16'd0;
                    n_entry = 1'b1;
                    n_ei    = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_deff == '0) begin
                    n_zero  = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    w_iv = 1'b1;
                    w_if = (r_ei == '0);
                    w_il = (r_ei == w_deff - 1'b1);
                    n_ei = r_ei + 1'b1;
                    if (w_il) begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (w_dv) begin
                    if (r_entry) begin
                        n_bdist = w_dd;
                        n_bnode = r_cur;
                        n_entry = 1'b0;
                        n_state = S_CHK;
                    end else begin
                        if (w_dd < r_bdist) begin
                            n_bdist = w_dd;
                            n_bnode = r_nb;
                            n_imp   = 1'b1;
                        end
                        n_state = S_NEXT;
                    end
                end
            end
            S_CHK: begin
                if (r_it == r_cfg.limit) begin
                    n_state = S_OUT;
                end else begin
                    n_nbase = NAW'(r_cur) * NAW'(DEGREE);
                    n_slot  = '0;
                    n_imp   = 1'b0;
                    n_state = S_DEG;
                end
            end
            S_DEG: begin
                n_degn = (32'(r_dq[6:0]) > DEGREE) ? DGCW'(DEGREE) : DGCW'(r_dq[6:0]);
                if (r_dq[6:0] == 7'd0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_NB;
                end
            end
            S_NB: begin
                if (w_nb_ok) begin
                    n_nb    = NW'(r_nq);
                    n_state = S_DEL;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_DEL: begin
                if (r_dq[7]) begin
                    n_state = S_NEXT;
                end else begin
                    n_vbase = VAW'(r_nb) * VAW'(DIMS);
                    n_ei    = '0;
                    n_state = S_ISSUE;
                end
            end
            S_NEXT: begin
                if (w_nslot < r_degn) begin
                    n_slot  = w_nslot;
                    n_state = S_NB;
                end else if (r_imp) begin
                    n_cur   = r_bnode;
                    n_it    = r_it + 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_zero  <= 1'b0;
            r_done  <= 1'b0;
            r_iv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_zero  <= n_zero;
            r_done  <= n_done;
            r_iv    <= w_iv;
        end
        r_if    <= w_if;
        r_il    <= w_il;
        r_cfg   <= n_cfg;
        r_cur   <= n_cur;
        r_vbase <= n_vbase;
        r_nbase <= n_nbase;
        r_ei    <= n_ei;
        r_it    <= n_it;
        r_slot  <= n_slot;
        r_degn  <= n_degn;
        r_nb    <= n_nb;
        r_bnode <= n_bnode;
        r_bdist <= n_bdist;
        r_imp   <= n_imp;
        r_entry <= n_entry;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_res.done      = r_done;
    assign o_res.node      = 11'(r_bnode);
    assign o_res.best_dist = r_bdist;

endmodule
`default_nettype wire

// File: rtl/graph_greedy_nearest_search_top.sv
// top level of the greedy nearest search over a neighbor graph
//
//  channel   signals                                   handshake
//  -------   ----------------------------------------  ------------------------------
//  command   i_cmd i_node i_slot i_elem_index ...      taken when i_start && !o_busy
//  result    o_best_node o_best_distance o_status      one cycle, marked by o_done
//  config    i_cfg_we i_cfg_idx i_cfg_data             written when i_cfg_we is high
//
//  table writes and query elements are written when they are accepted
//  a query element with i_query_last starts a walk; o_busy stays high until the
//  result is out: each distance streams min(dims_in_use, DIMS) elements through the
//  one element-per-cycle accumulator (none when dims_in_use is zero), and each
//  neighbor slot needs table reads
//  entry or empty errors answer on the next cycle without a walk
//  after reset o_busy is high while the degree table is cleared
//  the result is not held: o_done lasts one cycle and the receiver cannot stall it
`default_nettype none
module graph_greedy_nearest_search_top import ggns_pkg::*; #(
    parameter int NODES  = 1024,
    parameter int DEGREE = 64,
    parameter int DIMS   = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [9:0]         i_node,
    input  wire logic [5:0]         i_slot,
    input  wire logic [6:0]         i_elem_index,
    input  wire logic signed [15:0] i_elem_value,
    input  wire logic signed [10:0] i_nbr_id,
    input  wire logic [6:0]         i_degree,
    input  wire logic               i_deleted_mark,
    input  wire logic               i_query_last,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    output logic                    o_done,
    output logic signed [10:0]      o_best_node,
    output logic [39:0]             o_best_distance,
    output logic [1:0]              o_status
);

    // configuration registers
    logic [10:0] r_entry;
    logic [10:0] r_live;
    logic [15:0] r_limit;
    logic [7:0]  r_dims;
    logic [10:0] r_nodes;

    // early answer for a query that cannot walk
    logic        r_err_v, n_err_v;
    t_status     r_err_st, n_err_st;

    logic        w_accept;
    logic        w_last;
    logic        w_empty;
    logic        w_oor;
    logic        w_go;
    logic        w_busy;
    t_wcmd       w_cmd;
    t_walk_cfg   w_cfg;
    t_walk_res   w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= NODE_NONE;
            r_live  <= 11'd0;
            r_limit <= 16'd64;
            r_dims  <= 8'd128;
            r_nodes <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTRY: r_entry <= i_cfg_data[10:0];
                CFG_LIVE:  r_live  <= i_cfg_data[10:0];
                CFG_LIMIT: r_limit <= i_cfg_data;
                CFG_DIMS:  r_dims  <= i_cfg_data[7:0];
                CFG_NODES: r_nodes <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // caps against the built sizes
    assign w_cfg.entry = r_entry;
    assign w_cfg.n_eff = (17'(r_nodes) < 17'(NODES)) ? 17'(r_nodes) : 17'(NODES);
    assign w_cfg.d_eff = (11'(r_dims) < 11'(DIMS)) ? 11'(r_dims) : 11'(DIMS);
    assign w_cfg.limit = r_limit;

    assign w_accept = i_start && !w_busy;
    assign w_last   = w_accept && (i_cmd == CMD_QUERY) && i_query_last;
    assign w_empty  = r_entry[10] || (r_live == 11'd0);
    assign w_oor    = 17'(r_entry) >= w_cfg.n_eff;
    assign w_go     = w_last && !w_empty && !w_oor;

    assign w_cmd.we_vec       = w_accept && (i_cmd == CMD_VEC);
    assign w_cmd.we_nbr       = w_accept && (i_cmd == CMD_NBR);
    assign w_cmd.we_deg       = w_accept && (i_cmd == CMD_DEG);
    assign w_cmd.we_query     = w_accept && (i_cmd == CMD_QUERY);
    assign w_cmd.node         = i_node;
    assign w_cmd.slot         = i_slot;
    assign w_cmd.elem_index   = i_elem_index;
    assign w_cmd.elem_value   = i_elem_value;
    assign w_cmd.nbr_id       = i_nbr_id;
    assign w_cmd.degree       = i_degree;
    assign w_cmd.deleted_mark = i_deleted_mark;

    always_comb begin
        n_err_v  = w_last && (w_empty || w_oor);
        n_err_st = w_empty ? ST_EMPTY : ST_RANGE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_v <= 1'b0;
        end else begin
            r_err_v <= n_err_v;
        end
        r_err_st <= n_err_st;
    end

    ggns_walk #(
        .NODES  (NODES),
        .DEGREE (DEGREE),
        .DIMS   (DIMS)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_go    (w_go),
        .i_cfg   (w_cfg),
        .o_busy  (w_busy),
        .o_res   (w_res)
    );

    // walk result or early error answer, never both in one cycle
    assign o_busy          = w_busy;
    assign o_done          = r_err_v || w_res.done;
    assign o_best_node     = w_res.done ? w_res.node : NODE_NONE;
    assign o_best_distance = w_res.done ? w_res.best_dist : DIST_MAX;
    assign o_status        = w_res.done ? ST_OK : r_err_st;

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_err_v && w_res.done))
        else $error("error answer and walk result collide");

    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> o_busy)
        else $error("walk started but block not busy");

    a_err_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_best_node == NODE_NONE))
        else $error("error result carries a node");

    a_err_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last && (w_empty || w_oor)) |=> (o_done && (o_status != ST_OK)))
        else $error("early error answer missing");

endmodule
`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the greedy nearest search block
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import ggns_pkg::*;

    // run length in items and safety limit in clock cycles
    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASES       = 10;
    localparam longint CYCLE_LIMIT = 64'd100_000_000;

    // one command item as driven on the ports
    typedef struct {
        t_cmd               cmd;
        logic [9:0]         node;
        logic [5:0]         slot;
        logic [6:0]         elem_index;
        logic signed [15:0] elem_value;
        logic signed [10:0] nbr_id;
        logic [6:0]         degree;
        logic               deleted_mark;
        logic               query_last;
    } t_item;

    // one walk answer
    typedef struct {
        logic signed [10:0] node;
        logic [39:0]        best_dist;
        t_status            status;
    } t_answer;

    // directed table row: either a register write or an item
    typedef struct {
        bit       is_cfg;
        t_cfg_idx idx;
        logic [15:0] data;
        t_item    item;
        bit       typed;
        t_status  status;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [1:0]         i_cmd;
    logic [9:0]         i_node;
    logic [5:0]         i_slot;
    logic [6:0]         i_elem_index;
    logic signed [15:0] i_elem_value;
    logic signed [10:0] i_nbr_id;
    logic [6:0]         i_degree;
    logic               i_deleted_mark;
    logic               i_query_last;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               o_done;
    logic signed [10:0] o_best_node;
    logic [39:0]        o_best_distance;
    logic [1:0]         o_status;

    graph_greedy_nearest_search_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_node         (i_node),
        .i_slot         (i_slot),
        .i_elem_index   (i_elem_index),
        .i_elem_value   (i_elem_value),
        .i_nbr_id       (i_nbr_id),
        .i_degree       (i_degree),
        .i_deleted_mark (i_deleted_mark),
        .i_query_last   (i_query_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_best_node    (o_best_node),
        .o_best_distance(o_best_distance),
        .o_status       (o_status)
    );

    // shadow copy of the graph tables
    logic signed [15:0] node_vec [0:1023][0:127];
    logic signed [10:0] nbr_ids  [0:1023][0:63];
    logic [6:0]         node_deg [0:1023];
    logic               node_del [0:1023];
    logic signed [15:0] query_shadow [0:127];

    // shadow copy of the registers
    logic signed [10:0] reg_entry;
    logic [10:0]        reg_live;
    logic [15:0]        reg_limit;
    logic [7:0]         reg_dims;
    logic [10:0]        reg_nodes;

    t_answer pending_answers[$];
    t_row    directed[$];
    bit      failed;
    longint  cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // exact squared distance from a stored node to the query, saturating
    function automatic logic [39:0] query_distance(int id, int dims);
        longint acc;
        longint diff;
        acc = 0;
        for (int i = 0; i < dims; i++) begin
            diff = longint'(node_vec[id][i]) - longint'(query_shadow[i]);
            acc += diff * diff;
            if (acc > longint'(DIST_MAX)) acc = longint'(DIST_MAX);
        end
        return acc[39:0];
    endfunction

    // greedy walk from the entry node under the current registers
    function automatic t_answer greedy_walk();
        t_answer ans;
        int n_eff;
        int d_eff;
        int cur;
        int base;
        int deg;
        int nb;
        logic [39:0] cur_dist;
        logic [39:0] d;
        bit improved;
        n_eff = (reg_nodes < 1024) ? int'(reg_nodes) : 1024;
        d_eff = (reg_dims < 128) ? int'(reg_dims) : 128;
        if (reg_entry < 0 || reg_live == 0) begin
            ans.node = NODE_NONE;
            ans.best_dist = DIST_MAX;
            ans.status = ST_EMPTY;
            return ans;
        end
        if (int'(reg_entry) >= n_eff) begin
            ans.node = NODE_NONE;
            ans.best_dist = DIST_MAX;
            ans.status = ST_RANGE;
            return ans;
        end
        cur = int'(reg_entry);
        cur_dist = query_distance(cur, d_eff);
        for (int it = 0; it < int'(reg_limit); it++) begin
            deg = (node_deg[cur] > 64) ? 64 : int'(node_deg[cur]);
            improved = 1'b0;
            // neighbors of the node where this round started
            base = cur;
            for (int s = 0; s < deg; s++) begin
                nb = int'(nbr_ids[base][s]);
                if (nb < 0 || nb >= n_eff || node_del[nb]) continue;
                d = query_distance(nb, d_eff);
                if (d < cur_dist) begin
                    cur = nb;
                    cur_dist = d;
                    improved = 1'b1;
                end
            end
            if (!improved) break;
        end
        ans.node = cur[10:0];
        ans.best_dist = cur_dist;
        ans.status = ST_OK;
        return ans;
    endfunction

    // applies one accepted item to the shadow state, returns 1 if it answers
    function automatic bit apply_item(t_item it, output t_answer ans);
        ans.node = '0;
        ans.best_dist = '0;
        ans.status = ST_OK;
        case (it.cmd)
            CMD_VEC: node_vec[it.node][it.elem_index] = it.elem_value;
            CMD_NBR: nbr_ids[it.node][it.slot] = it.nbr_id;
            CMD_DEG: begin
                node_deg[it.node] = it.degree;
                node_del[it.node] = it.deleted_mark;
            end
            default: begin
                query_shadow[it.elem_index] = it.elem_value;
                if (it.query_last) begin
                    ans = greedy_walk();
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // neighbor ids that never lead onto an unwritten vector:
    // empty, the filled nodes, or the always-deleted high block
    function automatic logic signed [10:0] safe_neighbor();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -11'sd1;
        if (r < 7) return 11'($urandom_range(0, 3));
        return 11'($urandom_range(1020, 1023));
    endfunction

    function automatic t_item blank_item();
        t_item it;
        it = '{cmd: CMD_QUERY, default: '0};
        return it;
    endfunction

    // drive one item, return once it has been accepted
    task automatic send_item(t_item it, bit typed, t_status st);
        int gap;
        t_answer ans;
        bit answers;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd          = it.cmd;
        i_node         = it.node;
        i_slot         = it.slot;
        i_elem_index   = it.elem_index;
        i_elem_value   = it.elem_value;
        i_nbr_id       = it.nbr_id;
        i_degree       = it.degree;
        i_deleted_mark = it.deleted_mark;
        i_query_last   = it.query_last;
        i_start        = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        answers = apply_item(it, ans);
        if (answers) begin
            // error answers are typed in the table, checked against the walk too
            if (typed) begin
                if (ans.status != st) begin
                    $display("%0t table row status %0d disagrees with walk %0d",
                             $time, st, ans.status);
                    failed = 1'b1;
                end
                ans.node = NODE_NONE;
                ans.best_dist = DIST_MAX;
                ans.status = st;
            end
            pending_answers.push_back(ans);
        end
        @(negedge i_clk);
    endtask

    // register write once the block has settled
    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_start = 1'b0;
        while (pending_answers.size() != 0 || o_busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_ENTRY: reg_entry = data[10:0];
            CFG_LIVE:  reg_live  = data[10:0];
            CFG_LIMIT: reg_limit = data;
            CFG_DIMS:  reg_dims  = data[7:0];
            default:   reg_nodes = data[10:0];
        endcase
    endtask

    function automatic t_row cfg_row(t_cfg_idx idx, logic [15:0] data);
        t_row r;
        r = '{is_cfg: 1'b1, idx: idx, data: data, item: blank_item(),
              typed: 1'b0, status: ST_OK};
        return r;
    endfunction

    function automatic t_row item_row(t_cmd cmd, int node, int slot, int ei, int ev,
                                      int nb, int deg, bit del, bit last,
                                      bit typed, t_status st);
        t_row r;
        r.is_cfg = 1'b0;
        r.idx = CFG_ENTRY;
        r.data = '0;
        r.item = '{cmd: cmd, node: node[9:0], slot: slot[5:0], elem_index: ei[6:0],
                   elem_value: ev[15:0], nbr_id: nb[10:0], degree: deg[6:0],
                   deleted_mark: del, query_last: last};
        r.typed = typed;
        r.status = st;
        return r;
    endfunction

    // random item aimed at the filled part of the graph
    function automatic t_item random_item();
        t_item it;
        int r;
        it.node = $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1023))
                : ($urandom_range(0, 7) == 0 ? 10'd1023 : 10'($urandom_range(0, 3)));
        // only node 1023 has all slots written, the others the first eight
        it.slot = it.node == 10'd1023 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
        it.elem_index = 7'($urandom_range(0, 127));
        it.elem_value = 16'($urandom);
        it.nbr_id = safe_neighbor();
        r = $urandom_range(0, 49);
        if (it.node == 10'd1023) begin
            it.degree = r < 10 ? 7'($urandom_range(65, 127))
                      : (r < 20 ? 7'd64 : 7'($urandom_range(0, 8)));
        end else begin
            it.degree = 7'($urandom_range(0, 8));
        end
        it.deleted_mark = $urandom_range(0, 4) == 0;
        it.query_last = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        it.cmd = r < 30 ? CMD_VEC : (r < 55 ? CMD_NBR : (r < 80 ? CMD_DEG : CMD_QUERY));
        // the high block stays deleted so it is never walked onto
        if (it.cmd == CMD_DEG && it.node >= 1020 && it.node <= 1022) it.deleted_mark = 1'b1;
        return it;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected result node %0d dist %0h status %0d",
                         $time, o_best_node, o_best_distance, o_status);
                failed = 1'b1;
            end else begin
                exp_ans = pending_answers.pop_front();
                if (o_best_node !== exp_ans.node) begin
                    $display("%0t best_node expected %0d actual %0d",
                             $time, exp_ans.node, o_best_node);
                    failed = 1'b1;
                end
                if (o_best_distance !== exp_ans.best_dist) begin
                    $display("%0t best_distance expected %0h actual %0h",
                             $time, exp_ans.best_dist, o_best_distance);
                    failed = 1'b1;
                end
                if (o_status !== exp_ans.status) begin
                    $display("%0t status expected %0d actual %0d",
                             $time, exp_ans.status, o_status);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("graph_greedy_nearest_search_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_item it;
        int wait_cycles;
        failed   = 1'b0;
        cycles   = 0;
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_cmd    = CMD_VEC;
        i_node   = '0;
        i_slot   = '0;
        i_elem_index   = '0;
        i_elem_value   = '0;
        i_nbr_id       = '0;
        i_degree       = '0;
        i_deleted_mark = 1'b0;
        i_query_last   = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ENTRY;
        i_cfg_data = '0;
        reg_entry = -11'sd1;
        reg_live  = 11'd0;
        reg_limit = 16'd64;
        reg_dims  = 8'd128;
        reg_nodes = 11'd1024;
        for (int n = 0; n < 1024; n++) begin
            node_deg[n] = '0;
            node_del[n] = 1'b0;
            for (int i = 0; i < 128; i++) node_vec[n][i] = '0;
            for (int s = 0; s < 64; s++) nbr_ids[n][s] = '0;
        end
        for (int i = 0; i < 128; i++) query_shadow[i] = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        // degree table clearing pass after reset
        while (o_busy) @(negedge i_clk);

        // fill vectors of nodes 0..3 and 1023, the first eight neighbor slots of
        // nodes 0..3 and all slots of 1023, the whole query, and mark the high
        // block deleted; walks then only touch written entries
        for (int k = 0; k < 5; k++) begin
            for (int i = 0; i < 128; i++) begin
                it = blank_item();
                it.cmd = CMD_VEC;
                it.node = k == 4 ? 10'd1023 : 10'(k);
                it.elem_index = 7'(i);
                it.elem_value = 16'($urandom_range(0, 4095)) - 16'sd2048;
                send_item(it, 1'b0, ST_OK);
            end
            for (int s = 0; s < (k == 4 ? 64 : 8); s++) begin
                it = blank_item();
                it.cmd = CMD_NBR;
                it.node = k == 4 ? 10'd1023 : 10'(k);
                it.slot = 6'(s);
                it.nbr_id = safe_neighbor();
                send_item(it, 1'b0, ST_OK);
            end
            it = blank_item();
            it.cmd = CMD_DEG;
            it.node = k == 4 ? 10'd1023 : 10'(k);
            it.degree = 7'($urandom_range(1, 6));
            send_item(it, 1'b0, ST_OK);
        end
        for (int n = 1020; n < 1023; n++) begin
            it = blank_item();
            it.cmd = CMD_DEG;
            it.node = 10'(n);
            it.deleted_mark = 1'b1;
            send_item(it, 1'b0, ST_OK);
        end
        for (int i = 0; i < 128; i++) begin
            it = blank_item();
            it.elem_index = 7'(i);
            it.elem_value = 16'($urandom_range(0, 4095)) - 16'sd2048;
            send_item(it, 1'b0, ST_OK);
        end

        // directed part: no entry, entry out of range, zero limit, extremes,
        // deleted entry, deleted and empty neighbors, all-ones degree
        directed.push_back(item_row(CMD_QUERY, 0, 0, 0, 5, 0, 0, 0, 1, 1, ST_EMPTY));
        directed.push_back(cfg_row(CFG_LIVE, 16'd1));
        directed.push_back(cfg_row(CFG_ENTRY, 16'd3));
        directed.push_back(cfg_row(CFG_NODES, 16'd2));
        directed.push_back(item_row(CMD_QUERY, 0, 0, 1, 7, 0, 0, 0, 1, 1, ST_RANGE));
        directed.push_back(cfg_row(CFG_NODES, 16'd1024));
        directed.push_back(cfg_row(CFG_LIMIT, 16'd0));
        directed.push_back(item_row(CMD_QUERY, 0, 0, 2, 9, 0, 0, 0, 1, 0, ST_OK));
        directed.push_back(cfg_row(CFG_LIMIT, 16'd65535));
        directed.push_back(cfg_row(CFG_DIMS, 16'd128));
        directed.push_back(item_row(CMD_VEC, 3, 0, 0, -32768, 0, 0, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_VEC, 1023, 0, 127, 32767, 0, 0, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_NBR, 3, 0, 0, 0, 2, 0, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_NBR, 3, 1, 0, 0, -1, 0, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_NBR, 3, 2, 0, 0, 1020, 0, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_NBR, 1023, 63, 0, 0, 1023, 0, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_DEG, 1023, 0, 0, 0, 0, 127, 1, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_QUERY, 0, 0, 0, 32767, 0, 0, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_QUERY, 0, 0, 127, -32768, 0, 0, 0, 1, 0, ST_OK));
        directed.push_back(cfg_row(CFG_DIMS, 16'd1));
        directed.push_back(cfg_row(CFG_ENTRY, 16'd1023));
        directed.push_back(item_row(CMD_QUERY, 0, 0, 0, -32768, 0, 0, 0, 1, 0, ST_OK));
        directed.push_back(cfg_row(CFG_LIVE, 16'd1024));
        directed.push_back(item_row(CMD_DEG, 1023, 0, 0, 0, 0, 64, 0, 0, 0, ST_OK));
        directed.push_back(item_row(CMD_QUERY, 0, 0, 5, 1, 0, 0, 0, 1, 0, ST_OK));
        foreach (directed[r]) begin
            if (directed[r].is_cfg) write_reg(directed[r].idx, directed[r].data);
            else send_item(directed[r].item, directed[r].typed, directed[r].status);
        end

        // random phases, each under a fresh register setting
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_ENTRY, $urandom_range(0, 7) == 0 ? 16'hFFFF
                      : ($urandom_range(0, 7) == 0 ? 16'd1023 : 16'($urandom_range(0, 3))));
            write_reg(CFG_LIVE, $urandom_range(0, 9) == 0 ? 16'd0
                      : ($urandom_range(0, 3) == 0 ? 16'd1024 : 16'($urandom_range(1, 1024))));
            write_reg(CFG_LIMIT, p == 0 ? 16'd0 : (p == 1 ? 16'd65535
                      : ($urandom_range(0, 1) ? 16'd64 : 16'($urandom))));
            write_reg(CFG_DIMS, p == 2 ? 16'd128 : (p == 3 ? 16'd1
                      : 16'($urandom_range(1, 16))));
            write_reg(CFG_NODES, $urandom_range(0, 2) == 0 ? 16'd1024
                      : 16'($urandom_range(1, 5)));
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) send_item(random_item(), 1'b0, ST_OK);
        end

        i_start = 1'b0;
        wait_cycles = 0;
        while (pending_answers.size() != 0 && wait_cycles < 2_000_000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(negedge i_clk);
        if (!failed && pending_answers.size() == 0) begin
            $display("graph_greedy_nearest_search_top: match");
        end else begin
            $display("graph_greedy_nearest_search_top: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
